>>> rtl/core/lcpg_pkg.sv
// Package for the lane curve point generator: request and result structs,
// fixed-point constants and the shared rounding and saturation functions.
// No dependencies.
package lcpg_pkg;

  localparam int unsigned Points    = 50;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned SlotW     = 6;
  localparam int unsigned ScaleW    = 13;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned TableAddrW = $clog2(Points);
  localparam int unsigned ProdW     = 68;

  localparam logic signed [31:0] LaneThresh = -(32'sd10000 <<< FracBits);

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    CmdLoad     = 1'b0,
    CmdEvaluate = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               cmd;
    logic [SlotW-1:0]   slot;
    logic signed [31:0] curve_p0;
    logic signed [31:0] curve_p1;
    logic signed [31:0] curve_p2;
    logic signed [31:0] curve_p3;
    logic signed [31:0] curve_p4;
    logic signed [31:0] curve_p5;
    logic signed [31:0] curve_p6;
    logic signed [31:0] curve_p7;
    logic signed [31:0] logit_background;
    logic signed [31:0] logit_lane;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0]   lane_slot;
    logic [5:0]         point_number;
    logic signed [15:0] x_pixel;
    logic signed [15:0] y_pixel;
    logic               pole_hit;
    logic               last_point;
  } rsp_t;

  // divide by 2^FracBits, truncating toward zero
  function automatic logic signed [ProdW-1:0] frac_trunc(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] bias;
    bias = v[ProdW-1] ? ProdW'((68'sd1 <<< FracBits) - 68'sd1) : '0;
    return (v + bias) >>> FracBits;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ProdW-1:0] v);
    if (v > 68'sd32767) begin
      return 16'sd32767;
    end else if (v < -68'sd32768) begin
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

endpackage

>>> rtl/core/lcpg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcpg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/lane_curve_point_generator.sv
// Lane curve point generator top level: sequencer, shared multiplier and
// bit-serial divider. Depends on lcpg_pkg and lcpg_ram.
// Load and non-lane evaluate requests leave the block idle. An evaluate
// request of a lane stalls the input until all 50 points are issued; the
// one-bit-per-cycle divider runs three divisions per point, none at a pole.
// Reset: idle, width 640, height 360, table undefined.
module lane_curve_point_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lcpg_pkg::req_t                   in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lcpg_pkg::rsp_t                   out_rsp_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lcpg_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [lcpg_pkg::ScaleW-1:0]      cfg_data_i
);

  typedef enum logic [12:0] {
    StIdle  = 13'b0000000000001,
    StRead  = 13'b0000000000010,
    StMulT  = 13'b0000000000100,
    StYCalc = 13'b0000000001000,
    StMulH  = 13'b0000000010000,
    StMulE  = 13'b0000000100000,
    StESave = 13'b0000001000000,
    StDiv1  = 13'b0000010000000,
    StDiv2  = 13'b0000100000000,
    StDiv3  = 13'b0001000000000,
    StSum   = 13'b0010000000000,
    StMulX  = 13'b0100000000000,
    StOut   = 13'b1000000000000
  } state_e;

  localparam int unsigned PW = lcpg_pkg::ProdW;
  localparam int unsigned AW = lcpg_pkg::TableAddrW;

  state_e state_q, state_d;

  logic [lcpg_pkg::ScaleW-1:0] width_q, height_q;
  logic [lcpg_pkg::SlotW-1:0]  slot_q;
  logic signed [31:0] p0_q, p3_q, p4_q, p5_q, p6_q, p7_q, p2_q;
  logic signed [32:0] diff_q;
  logic [AW-1:0]      k_q;
  logic signed [31:0] y_q;
  logic signed [32:0] d_q;
  logic [32:0]        dmag_q;
  logic               pole_q;
  logic signed [15:0] ypix_q;
  logic signed [47:0] e_q;
  logic signed [57:0] a_q;
  logic signed [33:0] xv_q;
  logic signed [PW-1:0] prod_q;
  logic [63:0]        nq_q;
  logic [32:0]        rem_q;
  logic [6:0]         cnt_q;
  logic               out_valid_q;
  lcpg_pkg::rsp_t     out_q;

  logic [31:0]        ram_rdata;
  logic               in_acc, ram_we, out_free, is_lane;
  logic signed [33:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_tr;
  logic signed [49:0] y_wide;
  logic signed [31:0] y_sat;
  logic signed [32:0] d_new;
  logic [33:0]        shifted;
  logic               ge;
  logic [32:0]        rem_step;
  logic [63:0]        nq_step;
  logic [31:0]        p2_mag, p4_mag;
  logic [56:0]        amag;
  logic signed [48:0] b_val;
  logic signed [59:0] xv_wide;
  logic signed [33:0] xv_sat;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign ram_we = in_acc && (in_req_i.cmd == lcpg_pkg::CmdLoad)
                  && ({1'b0, in_req_i.slot} < 7'(lcpg_pkg::Points));
  assign is_lane = (in_req_i.logit_lane > in_req_i.logit_background)
                   && (in_req_i.logit_lane > lcpg_pkg::LaneThresh);

  lcpg_ram #(
    .Width (32),
    .Depth (lcpg_pkg::Points)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_req_i.slot[AW-1:0]),
    .wdata_i (in_req_i.curve_p0),
    .raddr_i (k_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StMulT: begin
        mul_a = 34'($signed(ram_rdata));
        mul_b = 34'(diff_q);
      end
      StMulH: begin
        mul_a = 34'(y_q);
        mul_b = $signed({21'b0, height_q});
      end
      StMulE: begin
        mul_a = 34'(p6_q);
        mul_b = 34'(y_q);
      end
      StMulX: begin
        mul_a = xv_q;
        mul_b = $signed({21'b0, width_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_tr = lcpg_pkg::frac_trunc(prod_q);
  assign y_wide  = 50'(p0_q) + prod_tr[49:0];
  always_comb begin
    if (y_wide > 50'sd2147483647) begin
      y_sat = 32'sh7fffffff;
    end else if (y_wide < -50'sd2147483648) begin
      y_sat = 32'sh80000000;
    end else begin
      y_sat = y_wide[31:0];
    end
  end
  assign d_new = 33'(y_sat) - 33'(p3_q);

  assign shifted  = {rem_q, nq_q[63]};
  assign ge       = shifted >= {1'b0, dmag_q};
  assign rem_step = ge ? 33'(shifted - {1'b0, dmag_q}) : shifted[32:0];
  assign nq_step  = {nq_q[62:0], ge};

  assign p2_mag = p2_q[31] ? 32'(-33'(p2_q)) : p2_q;
  assign p4_mag = p4_q[31] ? 32'(-33'(p4_q)) : p4_q;
  assign amag   = (nq_step > (64'd1 << 56)) ? (57'd1 << 56) : nq_step[56:0];
  assign b_val  = (p4_q[31] ^ d_q[32]) ? -$signed({1'b0, nq_q[47:0]})
                                       : $signed({1'b0, nq_q[47:0]});
  assign xv_wide = 60'(a_q) + 60'(b_val) + 60'(p5_q) + 60'(e_q) - 60'(p7_q);
  always_comb begin
    if (xv_wide > (60'sd1 <<< 32)) begin
      xv_sat = 34'sd1 <<< 32;
    end else if (xv_wide < -(60'sd1 <<< 32)) begin
      xv_sat = -(34'sd1 <<< 32);
    end else begin
      xv_sat = xv_wide[33:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc && (in_req_i.cmd == lcpg_pkg::CmdEvaluate) && is_lane) begin
          state_d = StRead;
        end
      end
      StRead:  state_d = StMulT;
      StMulT:  state_d = StYCalc;
      StYCalc: state_d = StMulH;
      StMulH:  state_d = StMulE;
      StMulE:  state_d = pole_q ? StOut : StESave;
      StESave: state_d = StDiv1;
      StDiv1:  state_d = (cnt_q == 7'd1) ? StDiv2 : StDiv1;
      StDiv2:  state_d = (cnt_q == 7'd1) ? StDiv3 : StDiv2;
      StDiv3:  state_d = (cnt_q == 7'd1) ? StSum : StDiv3;
      StSum:   state_d = StMulX;
      StMulX:  state_d = StOut;
      StOut: begin
        if (out_free) begin
          state_d = (k_q == AW'(lcpg_pkg::Points - 1)) ? StIdle : StRead;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      width_q     <= lcpg_pkg::ScaleW'(640);
      height_q    <= lcpg_pkg::ScaleW'(360);
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == lcpg_pkg::CfgImageWidth) begin
          width_q <= cfg_data_i;
        end else if (cfg_index_i == lcpg_pkg::CfgImageHeight) begin
          height_q <= cfg_data_i;
        end
      end
      if (state_q == StIdle) begin
        k_q <= '0;
      end else if ((state_q == StOut) && out_free) begin
        k_q <= k_q + AW'(1);
      end
      if ((state_q == StOut) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q <= in_req_i.slot;
      p0_q   <= in_req_i.curve_p0;
      diff_q <= 33'(in_req_i.curve_p1) - 33'(in_req_i.curve_p0);
      p2_q   <= in_req_i.curve_p2;
      p3_q   <= in_req_i.curve_p3;
      p4_q   <= in_req_i.curve_p4;
      p5_q   <= in_req_i.curve_p5;
      p6_q   <= in_req_i.curve_p6;
      p7_q   <= in_req_i.curve_p7;
    end
    if ((state_q == StMulT) || (state_q == StMulH) || (state_q == StMulE)
        || (state_q == StMulX)) begin
      prod_q <= PW'(mul_a * mul_b);
    end
    case (state_q)
      StYCalc: begin
        y_q    <= y_sat;
        d_q    <= d_new;
        dmag_q <= d_new[32] ? 33'(-d_new) : d_new;
        pole_q <= (d_new == '0);
      end
      StMulE: begin
        ypix_q <= lcpg_pkg::sat16(prod_tr);
      end
      StESave: begin
        e_q   <= prod_tr[47:0];
        nq_q  <= {p2_mag, 32'b0};
        rem_q <= '0;
        cnt_q <= 7'd48;
      end
      StDiv1: begin
        if (cnt_q == 7'd1) begin
          nq_q  <= {nq_step[47:0], 16'b0};
          rem_q <= '0;
          cnt_q <= 7'd64;
        end else begin
          nq_q  <= nq_step;
          rem_q <= rem_step;
          cnt_q <= cnt_q - 7'd1;
        end
      end
      StDiv2: begin
        if (cnt_q == 7'd1) begin
          a_q   <= p2_q[31] ? -$signed({1'b0, amag}) : $signed({1'b0, amag});
          nq_q  <= {p4_mag, 32'b0};
          rem_q <= '0;
          cnt_q <= 7'd48;
        end else begin
          nq_q  <= nq_step;
          rem_q <= rem_step;
          cnt_q <= cnt_q - 7'd1;
        end
      end
      StDiv3: begin
        nq_q  <= nq_step;
        rem_q <= rem_step;
        cnt_q <= cnt_q - 7'd1;
      end
      StSum: begin
        xv_q <= xv_sat;
      end
      StOut: begin
        if (out_free) begin
          out_q.lane_slot    <= slot_q;
          out_q.point_number <= 6'(k_q);
          out_q.x_pixel      <= pole_q ? 16'sd32767 : lcpg_pkg::sat16(prod_tr);
          out_q.y_pixel      <= ypix_q;
          out_q.pole_hit     <= pole_q;
          out_q.last_point   <= (k_q == AW'(lcpg_pkg::Points - 1));
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> tb/lcpg_checker.sv
`timescale 1ns / 100ps
// Checker for the lane curve point generator: watches the request, result and
// register channels, predicts every point and compares it. Depends on lcpg_pkg.
module lcpg_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  lcpg_pkg::req_t in_req_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  lcpg_pkg::rsp_t out_rsp_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [lcpg_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lcpg_pkg::ScaleW-1:0]  cfg_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  localparam longint One       = longint'(1) << lcpg_pkg::FracBits;
  localparam longint TermLimit = longint'(1) << 56;
  localparam longint XLimit    = longint'(1) << (16 + lcpg_pkg::FracBits);
  localparam longint YMax      = (longint'(1) << 31) - 1;
  localparam longint YMin      = -(longint'(1) << 31);

  logic [31:0]                 sample_mem [lcpg_pkg::Points];
  logic [lcpg_pkg::ScaleW-1:0] x_scale = 13'd640;
  logic [lcpg_pkg::ScaleW-1:0] y_scale = 13'd360;
  lcpg_pkg::rsp_t              point_q [$];
  int                          fails = 0;
  int                          pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic longint frac_down(input longint v);
    return (v < 0) ? -((-v) >>> lcpg_pkg::FracBits) : (v >>> lcpg_pkg::FracBits);
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [15:0] pixel16(input longint v);
    longint c;
    c = clamp(v, -32768, 32767);
    return c[15:0];
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    fails++;
  endtask

  task automatic predict_points(input lcpg_pkg::req_t r);
    longint p0, p1, p2, p3, p4, p5, p6, p7, lg0, lg1;
    longint t, y, d, r1, q, rem, qmag, a, b, e, xv;
    lcpg_pkg::rsp_t pt;
    p0 = longint'(r.curve_p0); p1 = longint'(r.curve_p1);
    p2 = longint'(r.curve_p2); p3 = longint'(r.curve_p3);
    p4 = longint'(r.curve_p4); p5 = longint'(r.curve_p5);
    p6 = longint'(r.curve_p6); p7 = longint'(r.curve_p7);
    lg0 = longint'(r.logit_background);
    lg1 = longint'(r.logit_lane);
    if (!(lg1 > lg0 && lg1 > -10000 * One)) return;
    for (int k = 0; k < lcpg_pkg::Points; k++) begin
      t = longint'($signed(sample_mem[k]));
      y = clamp(p0 + frac_down(t * (p1 - p0)), YMin, YMax);
      d = y - p3;
      pt.lane_slot    = r.slot;
      pt.point_number = 6'(k);
      pt.y_pixel      = pixel16(frac_down(y * longint'(y_scale)));
      pt.pole_hit     = (d == 0);
      pt.last_point   = (k == lcpg_pkg::Points - 1);
      if (d == 0) begin
        pt.x_pixel = 16'sd32767;
      end else begin
        r1   = (p2 * One) / d;
        q    = r1 / d;
        rem  = r1 % d;
        qmag = (q < 0) ? -q : q;
        if (qmag >= (longint'(1) << (56 - lcpg_pkg::FracBits))) begin
          a = (q < 0) ? -TermLimit : TermLimit;
        end else begin
          a = clamp(q * One + (rem * One) / d, -TermLimit, TermLimit);
        end
        b  = (p4 * One) / d;
        e  = frac_down(p6 * y);
        xv = clamp(a + b + p5 + e - p7, -XLimit, XLimit);
        pt.x_pixel = pixel16(frac_down(xv * longint'(x_scale)));
      end
      point_q.insert(point_q.size(), pt);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == lcpg_pkg::CfgImageWidth) x_scale = cfg_data_i;
        else if (cfg_index_i == lcpg_pkg::CfgImageHeight) y_scale = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_req_i.cmd == lcpg_pkg::CmdLoad) begin
          if (in_req_i.slot < lcpg_pkg::Points) sample_mem[in_req_i.slot] = in_req_i.curve_p0;
        end else begin
          predict_points(in_req_i);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (point_q.size() == 0) begin
          report("unexpected point number", out_rsp_i.point_number, -1);
        end else begin
          lcpg_pkg::rsp_t w;
          w = point_q.pop_front();
          if (out_rsp_i.lane_slot !== w.lane_slot)
            report("lane_slot", out_rsp_i.lane_slot, w.lane_slot);
          if (out_rsp_i.point_number !== w.point_number)
            report("point_number", out_rsp_i.point_number, w.point_number);
          if (out_rsp_i.x_pixel !== w.x_pixel)
            report("x_pixel", out_rsp_i.x_pixel, w.x_pixel);
          if (out_rsp_i.y_pixel !== w.y_pixel)
            report("y_pixel", out_rsp_i.y_pixel, w.y_pixel);
          if (out_rsp_i.pole_hit !== w.pole_hit)
            report("pole_hit", out_rsp_i.pole_hit, w.pole_hit);
          if (out_rsp_i.last_point !== w.last_point)
            report("last_point", out_rsp_i.last_point, w.last_point);
        end
      end
      pending = point_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, requests, register writes and receiver stalls.
// Depends on lcpg_pkg, lcpg_checker and lane_curve_point_generator.
module tb_top;

  localparam longint One = longint'(1) << lcpg_pkg::FracBits;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  lcpg_pkg::req_t              in_req = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  lcpg_pkg::rsp_t              out_rsp;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [lcpg_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [lcpg_pkg::ScaleW-1:0] cfg_data = '0;
  int                          fail_count, pending;
  int                          burst_left = 0;
  bit                          long_hold = 1'b0;
  longint                      cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lane_curve_point_generator u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_rsp_o(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  lcpg_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_rsp_i(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stall pattern: changes character every random stretch
  int stall_mode = 0, stall_len = 0;
  always @(posedge clk_i) begin
    if (stall_len == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_len  = $urandom_range(20, 2000);
    end else begin
      stall_len--;
    end
    case (stall_mode)
      0: out_stall <= long_hold;
      1: out_stall <= long_hold | ($urandom_range(0, 3) == 0);
      2: out_stall <= long_hold | ($urandom_range(0, 1) == 0);
      default: out_stall <= long_hold | ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 20000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [31:0] rnd_q(input int mag);
    return 32'($signed(longint'($urandom_range(0, 2 * mag))) - mag);
  endfunction

  function automatic logic signed [31:0] rnd_val();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return rnd_q(int'(4 * One));
  endfunction

  function automatic lcpg_pkg::req_t make_eval(input bit lane);
    lcpg_pkg::req_t r;
    r.cmd      = lcpg_pkg::CmdEvaluate;
    r.slot     = 6'($urandom_range(0, 63));
    r.curve_p0 = rnd_val();
    r.curve_p1 = rnd_val();
    r.curve_p2 = rnd_val();
    r.curve_p3 = rnd_val();
    r.curve_p4 = rnd_val();
    r.curve_p5 = rnd_val();
    r.curve_p6 = rnd_val();
    r.curve_p7 = rnd_val();
    r.logit_background = rnd_val();
    if (lane) begin
      r.logit_lane = 32'($urandom_range(0, 32'(8 * One)));
      if (r.logit_background >= r.logit_lane) r.logit_background = r.logit_lane - 1;
    end else begin
      r.logit_lane = ($urandom_range(0, 1)) ? rnd_val() : r.logit_background;
    end
    return r;
  endfunction

  function automatic lcpg_pkg::req_t make_load(input int idx, input logic [31:0] val);
    lcpg_pkg::req_t r;
    r = '0;
    r.curve_p1         = $urandom;
    r.curve_p2         = $urandom;
    r.curve_p3         = $urandom;
    r.curve_p4         = $urandom;
    r.curve_p5         = $urandom;
    r.curve_p6         = $urandom;
    r.curve_p7         = $urandom;
    r.logit_background = $urandom;
    r.logit_lane       = $urandom;
    r.cmd      = lcpg_pkg::CmdLoad;
    r.slot     = 6'(idx);
    r.curve_p0 = val;
    return r;
  endfunction

  task automatic send_req(input lcpg_pkg::req_t r);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (in_stall);
    burst_left--;
  endtask

  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input lcpg_pkg::cfg_idx_e idx,
                           input logic [lcpg_pkg::ScaleW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    lcpg_pkg::req_t r;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the table: ramp over 0..1, then extremes to out-of-range slots
    for (int i = 0; i < lcpg_pkg::Points; i++) begin
      send_req(make_load(i, 32'(i * One / (lcpg_pkg::Points - 1))));
    end
    send_req(make_load(lcpg_pkg::Points, 32'h7fff_ffff));
    send_req(make_load(63, 32'h8000_0000));

    // pole on the first point, logits just above the threshold
    r = make_eval(1'b0);
    r.curve_p3 = r.curve_p0;
    r.logit_lane = -(32'sd10000 <<< lcpg_pkg::FracBits) + 1;
    r.logit_background = 32'sh8000_0000;
    send_req(r);
    // exactly at the threshold and tied logits: no lane
    r.logit_lane = -(32'sd10000 <<< lcpg_pkg::FracBits);
    send_req(r);
    r.logit_lane = r.logit_background;
    send_req(r);
    // huge inverse square term just off the pole
    r = make_eval(1'b1);
    r.curve_p2 = 32'h7fff_ffff;
    r.curve_p3 = r.curve_p0 - 1;
    r.curve_p1 = r.curve_p0;
    send_req(r);
    // all fields at their extremes
    r = '1;
    r.cmd = lcpg_pkg::CmdEvaluate;
    r.logit_lane = 32'h7fff_ffff;
    send_req(r);
    r = {1'b1, 6'd0, {8{32'h8000_0000}}, 32'h8000_0000, 32'h7fff_ffff};
    send_req(r);
    r = {1'b1, 6'd0, {8{32'h7fff_ffff}}, 32'h0, 32'h7fff_ffff};
    send_req(r);
    settle();

    write_reg(lcpg_pkg::CfgImageWidth, 13'd4096);
    write_reg(lcpg_pkg::CfgImageHeight, 13'd1);
    send_req(make_eval(1'b1));
    send_req(make_eval(1'b1));
    settle();
    write_reg(lcpg_pkg::CfgImageWidth, 13'd0);
    write_reg(lcpg_pkg::CfgImageHeight, 13'h1fff);
    send_req(make_eval(1'b1));
    settle();
    write_reg(lcpg_pkg::CfgImageWidth, 13'd1);
    write_reg(lcpg_pkg::CfgImageHeight, 13'd4096);
    send_req(make_eval(1'b1));
    settle();

    // hold the receiver off while the sender keeps offering lanes
    fork
      begin
        long_hold = 1'b1;
        repeat (30000) @(posedge clk_i);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 4; i++) send_req(make_eval(1'b1));
    join
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) begin
        write_reg(lcpg_pkg::CfgImageWidth, 13'd640);
        write_reg(lcpg_pkg::CfgImageHeight, 13'd360);
      end else if (ph > 0) begin
        write_reg(lcpg_pkg::CfgImageWidth, 13'($urandom_range(1, 4096)));
        write_reg(lcpg_pkg::CfgImageHeight, 13'($urandom_range(1, 4096)));
      end
      for (int n = 0; n < 60; n++) begin
        case ($urandom_range(0, 9))
          0, 1: send_req(make_load(int'($urandom_range(0, 63)),
                         ($urandom_range(0, 3) == 0) ? $urandom
                                                     : $urandom_range(0, 32'(One))));
          2, 3, 4, 5: send_req(make_eval(1'b0));
          default: send_req(make_eval(1'b1));
        endcase
      end
      settle();
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lcpg_pkg.sv
rtl/core/lcpg_ram.sv
rtl/core/lane_curve_point_generator.sv
tb/lcpg_checker.sv
tb/tb_top.sv
